// ===== design/dhcpr_pkg.sv =====
// Shared types and constants for the DHCP reply option parser.
// Holds the parse phase enum, status and option codes, and the result word layout.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package dhcpr_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_COOKIE = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_NO_TYPE   = 3'd4;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_SUBNET   = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [7:0] HDR_LEN   = 8'd240;
    localparam logic [7:0] COOKIE_AT = 8'd236;
    localparam logic [7:0] XID_FIRST = 8'd4;
    localparam logic [7:0] XID_LAST  = 8'd7;
    localparam logic [7:0] YIA_FIRST = 8'd16;
    localparam logic [7:0] YIA_LAST  = 8'd19;

    localparam logic [3:0][7:0] COOKIE = {8'd99, 8'd83, 8'd130, 8'd99};

    localparam logic [4:0] PRES_SERVER = 5'b00001;
    localparam logic [4:0] PRES_SUBNET = 5'b00010;
    localparam logic [4:0] PRES_ROUTER = 5'b00100;
    localparam logic [4:0] PRES_DNS    = 5'b01000;
    localparam logic [4:0] PRES_LEASE  = 5'b10000;

    // Packed so that status lands in the lowest bits of the output word.
    typedef struct packed {
        logic [31:0] lease_seconds;
        logic [31:0] dns_address;
        logic [31:0] router_address;
        logic [31:0] netmask;
        logic [31:0] server_address;
        logic [4:0]  present_mask;
        logic [31:0] your_address;
        logic [31:0] transaction_id;
        logic [7:0]  msg_type;
        logic [2:0]  status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dhcp_reply_option_parser_top.sv =====
// Top level of the DHCP reply option parser: input register, parser and result register.
// Depends on dhcpr_pkg, dhcpr_parser and dhcpr_out_reg.
//
// The slave channel takes one packet byte per word on s_tdata, with s_tlast high on the
// final byte of the reply. The master channel gives one 240-bit result word for each
// reply, on the word that carried s_tlast, and nothing for the other bytes.
// A byte accepted into the input register is parsed at the next edge or, for a last byte,
// once the result register is free; the result is loaded at that same edge, so m_tvalid
// rises from the result register, which holds the word until the receiver takes it.
// One byte is taken every cycle while the result side keeps up; a run of bytes without
// a last flag never waits on the result side.
// When the receiver stalls, the held result stays on m_tdata and a pending last byte
// waits in the input register, which then deasserts s_tready until the result is taken.
// Reset (aresetn low at a clock edge) empties both registers and returns the parser to
// the start of a reply; after a result the parser also starts over by itself.
`default_nettype none

module dhcp_reply_option_parser_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte[7:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [239:0]      m_tdata    // status, msg_type, transaction_id,
                                         // your_address, present_mask, server_address,
                                         // netmask, router_address, dns_address,
                                         // lease_seconds
);

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;
    logic               out_free;
    logic               consume;
    logic               res_valid;
    dhcpr_pkg::result_t res;

    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dhcpr_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .consume      (consume),
        .data_byte    (in_data_reg),
        .last_byte    (in_last_reg),
        .result       (res),
        .result_valid (res_valid)
    );

    dhcpr_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .result   (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/dhcpr_parser.sv =====
// Byte-wise parse state of the DHCP reply: header capture, cookie check and option walk.
// Builds the result word on the last byte and returns to its reset state afterward.
// Depends on dhcpr_pkg.
`default_nettype none

module dhcpr_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              consume,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output dhcpr_pkg::result_t     result,
    output logic                   result_valid
);

    logic [7:0]        pos_reg, pos_next;
    dhcpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        rem_reg, rem_next;
    logic [2:0]        obi_reg, obi_next;
    logic [31:0]       gather_reg, gather_next;
    logic              cookie_reg, cookie_next;
    logic [31:0]       xid_reg, xid_next;
    logic [31:0]       yia_reg, yia_next;
    logic [7:0]        mtype_reg, mtype_next;
    logic [4:0]        pres_reg, pres_next;
    logic [31:0]       server_reg, server_next;
    logic [31:0]       subnet_reg, subnet_next;
    logic [31:0]       router_reg, router_next;
    logic [31:0]       dns_reg, dns_next;
    logic [31:0]       lease_reg, lease_next;
    logic              fits;
    logic              take;
    logic [2:0]        status;

    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        rem_next    = rem_reg;
        obi_next    = obi_reg;
        gather_next = gather_reg;
        cookie_next = cookie_reg;
        xid_next    = xid_reg;
        yia_next    = yia_reg;
        mtype_next  = mtype_reg;
        pres_next   = pres_reg;
        server_next = server_reg;
        subnet_next = subnet_reg;
        router_next = router_reg;
        dns_next    = dns_reg;
        lease_next  = lease_reg;
        fits        = 1'b0;
        take        = 1'b0;

        unique case (phase_reg)
            dhcpr_pkg::PH_HEADER: begin
                if (pos_reg >= dhcpr_pkg::XID_FIRST && pos_reg <= dhcpr_pkg::XID_LAST) begin
                    xid_next = {xid_reg[23:0], data_byte};
                end else if (pos_reg >= dhcpr_pkg::YIA_FIRST &&
                             pos_reg <= dhcpr_pkg::YIA_LAST) begin
                    yia_next = {yia_reg[23:0], data_byte};
                end else if (pos_reg >= dhcpr_pkg::COOKIE_AT) begin
                    if (data_byte != dhcpr_pkg::COOKIE[pos_reg[1:0]]) begin
                        cookie_next = 1'b0;
                    end
                end
            end
            dhcpr_pkg::PH_CODE: begin
                if (data_byte == dhcpr_pkg::OPT_END) begin
                    phase_next = dhcpr_pkg::PH_DONE;
                end else if (data_byte != dhcpr_pkg::OPT_PAD) begin
                    code_next  = data_byte;
                    phase_next = dhcpr_pkg::PH_LEN;
                end
            end
            dhcpr_pkg::PH_LEN: begin
                case (code_reg) inside
                    dhcpr_pkg::OPT_MSG_TYPE: fits = (data_byte == 8'd1);
                    dhcpr_pkg::OPT_SERVER, dhcpr_pkg::OPT_SUBNET, dhcpr_pkg::OPT_LEASE:
                        fits = (data_byte == 8'd4);
                    dhcpr_pkg::OPT_ROUTER, dhcpr_pkg::OPT_DNS: fits = (data_byte >= 8'd4);
                    default: fits = 1'b0;
                endcase
                if (!fits) begin
                    code_next = dhcpr_pkg::OPT_PAD;
                end
                rem_next    = data_byte;
                obi_next    = 3'd0;
                gather_next = 32'd0;
                phase_next  = (data_byte == 8'd0) ? dhcpr_pkg::PH_CODE : dhcpr_pkg::PH_DATA;
            end
            dhcpr_pkg::PH_DATA: begin
                if (obi_reg < 3'd4) begin
                    gather_next = {gather_reg[23:0], data_byte};
                    obi_next    = obi_reg + 3'd1;
                end
                rem_next = rem_reg - 8'd1;
                if (rem_next == 8'd0) begin
                    take       = 1'b1;
                    phase_next = dhcpr_pkg::PH_CODE;
                end
            end
            dhcpr_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (take) begin
            case (code_reg)
                dhcpr_pkg::OPT_MSG_TYPE: mtype_next = gather_next[7:0];
                dhcpr_pkg::OPT_SERVER: begin
                    server_next = gather_next;
                    pres_next   = pres_next | dhcpr_pkg::PRES_SERVER;
                end
                dhcpr_pkg::OPT_SUBNET: begin
                    subnet_next = gather_next;
                    pres_next   = pres_next | dhcpr_pkg::PRES_SUBNET;
                end
                dhcpr_pkg::OPT_ROUTER: begin
                    router_next = gather_next;
                    pres_next   = pres_next | dhcpr_pkg::PRES_ROUTER;
                end
                dhcpr_pkg::OPT_DNS: begin
                    dns_next  = gather_next;
                    pres_next = pres_next | dhcpr_pkg::PRES_DNS;
                end
                dhcpr_pkg::OPT_LEASE: begin
                    lease_next = gather_next;
                    pres_next  = pres_next | dhcpr_pkg::PRES_LEASE;
                end
                default: begin
                end
            endcase
        end

        if (pos_reg < dhcpr_pkg::HDR_LEN) begin
            pos_next = pos_reg + 8'd1;
            if (pos_next == dhcpr_pkg::HDR_LEN) begin
                phase_next = dhcpr_pkg::PH_CODE;
            end
        end
    end

    always_comb begin
        if (pos_next < dhcpr_pkg::HDR_LEN) begin
            status = dhcpr_pkg::ST_SHORT;
        end else if (!cookie_next) begin
            status = dhcpr_pkg::ST_BAD_COOKIE;
        end else if (phase_next == dhcpr_pkg::PH_LEN || phase_next == dhcpr_pkg::PH_DATA) begin
            status = dhcpr_pkg::ST_TRUNCATED;
        end else if (mtype_next == 8'd0) begin
            status = dhcpr_pkg::ST_NO_TYPE;
        end else begin
            status = dhcpr_pkg::ST_OK;
        end

        result        = '0;
        result.status = status;
        if (status != dhcpr_pkg::ST_SHORT && status != dhcpr_pkg::ST_BAD_COOKIE) begin
            result.msg_type       = mtype_next;
            result.transaction_id = xid_next;
            result.your_address   = yia_next;
            result.present_mask   = pres_next;
            result.server_address = server_next;
            result.netmask        = subnet_next;
            result.router_address = router_next;
            result.dns_address    = dns_next;
            result.lease_seconds  = lease_next;
        end
        result_valid = consume && last_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && last_byte)) begin
            pos_reg    <= 8'd0;
            phase_reg  <= dhcpr_pkg::PH_HEADER;
            code_reg   <= 8'd0;
            rem_reg    <= 8'd0;
            obi_reg    <= 3'd0;
            gather_reg <= 32'd0;
            cookie_reg <= 1'b1;
            xid_reg    <= 32'd0;
            yia_reg    <= 32'd0;
            mtype_reg  <= 8'd0;
            pres_reg   <= 5'd0;
            server_reg <= 32'd0;
            subnet_reg <= 32'd0;
            router_reg <= 32'd0;
            dns_reg    <= 32'd0;
            lease_reg  <= 32'd0;
        end else if (consume) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            rem_reg    <= rem_next;
            obi_reg    <= obi_next;
            gather_reg <= gather_next;
            cookie_reg <= cookie_next;
            xid_reg    <= xid_next;
            yia_reg    <= yia_next;
            mtype_reg  <= mtype_next;
            pres_reg   <= pres_next;
            server_reg <= server_next;
            subnet_reg <= subnet_next;
            router_reg <= router_next;
            dns_reg    <= dns_next;
            lease_reg  <= lease_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) pos_reg <= dhcpr_pkg::HDR_LEN)
        else $error("Byte position ran past the header length.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg < dhcpr_pkg::HDR_LEN) == (phase_reg == dhcpr_pkg::PH_HEADER))
        else $error("Header phase does not match the byte position.");

    assert property (@(posedge aclk) disable iff (!aresetn) obi_reg <= 3'd4)
        else $error("Option byte index exceeded one address.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && last_byte) |=> (pos_reg == 8'd0 && phase_reg == dhcpr_pkg::PH_HEADER))
        else $error("Parser did not restart after a result.");

endmodule

`default_nettype wire

// ===== design/dhcpr_out_reg.sv =====
// Result register of the DHCP reply parser, holding one word until the receiver takes it.
// Depends on dhcpr_pkg for the result layout.
`default_nettype none

module dhcpr_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire dhcpr_pkg::result_t result,
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [239:0]           m_tdata
);

    logic               valid_reg;
    dhcpr_pkg::result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) load |-> free)
        else $error("Result loaded over a word not yet taken.");

    assert property (@(posedge aclk) disable iff (!aresetn) load |=> valid_reg)
        else $error("Loaded result is not shown.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready && !load) |=> $stable(data_reg))
        else $error("Held result changed while waiting.");

endmodule

`default_nettype wire

// ===== tb/sv/tb_dhcp_reply_option_parser_top.sv =====
// Self-checking testbench for dhcp_reply_option_parser_top: streams whole DHCP replies
// byte by byte, checks every result word against an in-bench model or typed sheet row.
// Depends on dhcpr_pkg and the design files; needs no other input.
`default_nettype none

module tb_dhcp_reply_option_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_GOAL = 2000;
    localparam int RANDOM_REPLIES_MIN = 6;
    localparam logic [0:3][7:0] MAGIC = {8'd99, 8'd130, 8'd83, 8'd99};

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

    typedef enum logic [3:0] {
        OPTS_NONE,
        OPTS_FULL_SET,
        OPTS_TYPE_ZERO,
        OPTS_CUT_AT_LENGTH,
        OPTS_CUT_IN_DATA,
        OPTS_ODD_LENGTHS,
        OPTS_PAD_END_TAIL,
        OPTS_REPEATS,
        OPTS_LONG_LISTS,
        OPTS_END_IS_LAST,
        OPTS_EMPTY_OPTION,
        OPTS_RANDOM
    } plan_t;

    typedef struct packed {
        logic [9:0]  head_len;
        fill_t       fill;
        logic [7:0]  bad_at;
        plan_t       plan;
        logic        typed;
        logic [2:0]  want_status;
        logic [31:0] want_xid;
        logic [31:0] want_yiaddr;
    } packet_row_t;

    typedef struct packed {
        logic               typed;
        dhcpr_pkg::result_t reply;
    } sheet_entry_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;

    dhcp_reply_option_parser_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    packet_row_t sheet [0:18] = '{
        '{10'd1,   FILL_ONES,   8'd0,   OPTS_NONE,          1'b1, dhcpr_pkg::ST_SHORT,
          32'h0, 32'h0},
        '{10'd239, FILL_RANDOM, 8'd0,   OPTS_NONE,          1'b1, dhcpr_pkg::ST_SHORT,
          32'h0, 32'h0},
        '{10'd238, FILL_ZERO,   8'd237, OPTS_NONE,          1'b1, dhcpr_pkg::ST_SHORT,
          32'h0, 32'h0},
        '{10'd240, FILL_ONES,   8'd0,   OPTS_NONE,          1'b1, dhcpr_pkg::ST_NO_TYPE,
          32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{10'd240, FILL_RANDOM, 8'd236, OPTS_FULL_SET,      1'b1, dhcpr_pkg::ST_BAD_COOKIE,
          32'h0, 32'h0},
        '{10'd240, FILL_ZERO,   8'd237, OPTS_CUT_IN_DATA,   1'b1, dhcpr_pkg::ST_BAD_COOKIE,
          32'h0, 32'h0},
        '{10'd240, FILL_ONES,   8'd238, OPTS_END_IS_LAST,   1'b1, dhcpr_pkg::ST_BAD_COOKIE,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd239, OPTS_NONE,          1'b1, dhcpr_pkg::ST_BAD_COOKIE,
          32'h0, 32'h0},
        '{10'd240, FILL_ZERO,   8'd0,   OPTS_FULL_SET,      1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_TYPE_ZERO,     1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_CUT_AT_LENGTH, 1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_CUT_IN_DATA,   1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_ODD_LENGTHS,   1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_PAD_END_TAIL,  1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_REPEATS,       1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_LONG_LISTS,    1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_END_IS_LAST,   1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_RANDOM, 8'd0,   OPTS_EMPTY_OPTION,  1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0},
        '{10'd240, FILL_ONES,   8'd0,   OPTS_FULL_SET,      1'b0, dhcpr_pkg::ST_OK,
          32'h0, 32'h0}
    };

    logic [7:0]         pkt [$];
    sheet_entry_t       sheet_replies [$];
    dhcpr_pkg::result_t replies_due [$];

    int cycle_count = 0;
    int bytes_sent = 0;
    int replies_sent = 0;
    int words_checked = 0;
    int faults = 0;
    int burst_left = 0;
    int hold_cnt = 0;
    logic hold_val = 1'b0;
    int by_status [0:7];

    logic [7:0]         parse_pos;
    dhcpr_pkg::phase_t  parse_phase;
    logic [7:0]         opt_code;
    logic [7:0]         opt_left;
    logic [2:0]         opt_idx;
    logic [31:0]        opt_word;
    logic               cookie_ok;
    logic               opt_cut;
    dhcpr_pkg::result_t held;

    function automatic void parser_clear();
        parse_pos = 8'd0;
        parse_phase = dhcpr_pkg::PH_HEADER;
        opt_code = dhcpr_pkg::OPT_PAD;
        opt_left = 8'd0;
        opt_idx = 3'd0;
        opt_word = 32'd0;
        cookie_ok = 1'b1;
        opt_cut = 1'b0;
        held = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic               fits;
        dhcpr_pkg::result_t want;
        sheet_entry_t       entry;
        case (parse_phase)
            dhcpr_pkg::PH_HEADER: begin
                if (parse_pos >= dhcpr_pkg::XID_FIRST && parse_pos <= dhcpr_pkg::XID_LAST)
                    held.transaction_id = {held.transaction_id[23:0], b};
                else if (parse_pos >= dhcpr_pkg::YIA_FIRST && parse_pos <= dhcpr_pkg::YIA_LAST)
                    held.your_address = {held.your_address[23:0], b};
                else if (parse_pos >= dhcpr_pkg::COOKIE_AT && parse_pos < dhcpr_pkg::HDR_LEN)
                begin
                    if (b != MAGIC[parse_pos - dhcpr_pkg::COOKIE_AT])
                        cookie_ok = 1'b0;
                end
            end
            dhcpr_pkg::PH_CODE: begin
                if (b == dhcpr_pkg::OPT_END) begin
                    parse_phase = dhcpr_pkg::PH_DONE;
                end else if (b != dhcpr_pkg::OPT_PAD) begin
                    opt_code = b;
                    parse_phase = dhcpr_pkg::PH_LEN;
                end
            end
            dhcpr_pkg::PH_LEN: begin
                case (opt_code)
                    dhcpr_pkg::OPT_MSG_TYPE: fits = (b == 8'd1);
                    dhcpr_pkg::OPT_SERVER, dhcpr_pkg::OPT_SUBNET, dhcpr_pkg::OPT_LEASE:
                        fits = (b == 8'd4);
                    dhcpr_pkg::OPT_ROUTER, dhcpr_pkg::OPT_DNS: fits = (b >= 8'd4);
                    default: fits = 1'b0;
                endcase
                if (!fits)
                    opt_code = dhcpr_pkg::OPT_PAD;
                opt_left = b;
                opt_idx = 3'd0;
                opt_word = 32'd0;
                parse_phase = (b == 8'd0) ? dhcpr_pkg::PH_CODE : dhcpr_pkg::PH_DATA;
            end
            dhcpr_pkg::PH_DATA: begin
                if (opt_idx < 3'd4) begin
                    opt_word = {opt_word[23:0], b};
                    opt_idx++;
                end
                opt_left--;
                if (opt_left == 8'd0) begin
                    case (opt_code)
                        dhcpr_pkg::OPT_MSG_TYPE: held.msg_type = opt_word[7:0];
                        dhcpr_pkg::OPT_SERVER: begin
                            held.server_address = opt_word;
                            held.present_mask |= dhcpr_pkg::PRES_SERVER;
                        end
                        dhcpr_pkg::OPT_SUBNET: begin
                            held.netmask = opt_word;
                            held.present_mask |= dhcpr_pkg::PRES_SUBNET;
                        end
                        dhcpr_pkg::OPT_ROUTER: begin
                            held.router_address = opt_word;
                            held.present_mask |= dhcpr_pkg::PRES_ROUTER;
                        end
                        dhcpr_pkg::OPT_DNS: begin
                            held.dns_address = opt_word;
                            held.present_mask |= dhcpr_pkg::PRES_DNS;
                        end
                        dhcpr_pkg::OPT_LEASE: begin
                            held.lease_seconds = opt_word;
                            held.present_mask |= dhcpr_pkg::PRES_LEASE;
                        end
                        default: ;
                    endcase
                    parse_phase = dhcpr_pkg::PH_CODE;
                end
            end
            default: ;
        endcase

        if (parse_pos < dhcpr_pkg::HDR_LEN) begin
            parse_pos++;
            if (parse_pos == dhcpr_pkg::HDR_LEN)
                parse_phase = dhcpr_pkg::PH_CODE;
        end

        if (last) begin
            if (parse_phase == dhcpr_pkg::PH_LEN || parse_phase == dhcpr_pkg::PH_DATA)
                opt_cut = 1'b1;
            want = '0;
            if (parse_pos < dhcpr_pkg::HDR_LEN) begin
                want.status = dhcpr_pkg::ST_SHORT;
            end else if (!cookie_ok) begin
                want.status = dhcpr_pkg::ST_BAD_COOKIE;
            end else begin
                want = held;
                if (opt_cut)
                    want.status = dhcpr_pkg::ST_TRUNCATED;
                else if (held.msg_type == 8'd0)
                    want.status = dhcpr_pkg::ST_NO_TYPE;
                else
                    want.status = dhcpr_pkg::ST_OK;
            end
            if (sheet_replies.size() != 0) begin
                entry = sheet_replies.pop_front();
                if (entry.typed)
                    want = entry.reply;
            end
            replies_due.push_back(want);
            by_status[want.status]++;
            parser_clear();
        end
    endfunction

    function automatic logic field_differs(input string name, input logic [31:0] want,
                                           input logic [31:0] got, input logic loud);
        if (want === got)
            return 1'b0;
        if (loud)
            $display("result word %0d, %s: expected %h, got %h", words_checked, name,
                     want, got);
        return 1'b1;
    endfunction

    function automatic void check_reply(input dhcpr_pkg::result_t got);
        dhcpr_pkg::result_t want;
        logic               bad;
        logic               loud;
        if (replies_due.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("result word %0d arrived with nothing expected (status %0d)",
                         words_checked, got.status);
        end else begin
            want = replies_due.pop_front();
            loud = (faults < 10);
            bad = 1'b0;
            bad |= field_differs("status", want.status, got.status, loud);
            bad |= field_differs("msg_type", want.msg_type, got.msg_type, loud);
            bad |= field_differs("transaction_id", want.transaction_id, got.transaction_id,
                                 loud);
            bad |= field_differs("your_address", want.your_address, got.your_address, loud);
            bad |= field_differs("present_mask", want.present_mask, got.present_mask, loud);
            bad |= field_differs("server_address", want.server_address, got.server_address,
                                 loud);
            bad |= field_differs("netmask", want.netmask, got.netmask, loud);
            bad |= field_differs("router_address", want.router_address, got.router_address,
                                 loud);
            bad |= field_differs("dns_address", want.dns_address, got.dns_address, loud);
            bad |= field_differs("lease_seconds", want.lease_seconds, got.lease_seconds, loud);
            if (bad)
                faults++;
        end
        words_checked++;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            absorb_byte(s_tdata, s_tlast);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_reply(dhcpr_pkg::result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if (hold_cnt == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    hold_val = 1'b0;
                    hold_cnt = $urandom_range(1, 20);
                end
                1: begin
                    hold_val = 1'b1;
                    hold_cnt = $urandom_range(20, 200);
                end
                default: begin
                    hold_val = 1'($urandom_range(0, 1));
                    hold_cnt = 1;
                end
            endcase
        end
        hold_cnt--;
        m_tready <= hold_val;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result words outstanding", cycle_count,
                     replies_due.size());
            $display("tb_dhcp_reply_option_parser_top failed");
            $finish;
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        pkt.push_back(b);
    endfunction

    function automatic void put_bytes(input int n);
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_opt(input logic [7:0] code, input int len);
        put_byte(code);
        put_byte(8'(len));
        put_bytes(len);
    endfunction

    function automatic void put_type(input logic [7:0] value);
        put_byte(dhcpr_pkg::OPT_MSG_TYPE);
        put_byte(8'd1);
        put_byte(value);
    endfunction

    function automatic void put_header(input int len, input fill_t fill, input int bad_at);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            if (i >= dhcpr_pkg::COOKIE_AT && i < dhcpr_pkg::HDR_LEN)
                b = MAGIC[i - dhcpr_pkg::COOKIE_AT];
            if (bad_at != 0 && i == bad_at)
                b = b ^ 8'($urandom_range(1, 255));
            pkt.push_back(b);
        end
    endfunction

    function automatic logic [7:0] any_known_code();
        case ($urandom_range(0, 5))
            0: return dhcpr_pkg::OPT_MSG_TYPE;
            1: return dhcpr_pkg::OPT_SERVER;
            2: return dhcpr_pkg::OPT_SUBNET;
            3: return dhcpr_pkg::OPT_LEASE;
            4: return dhcpr_pkg::OPT_ROUTER;
            default: return dhcpr_pkg::OPT_DNS;
        endcase
    endfunction

    function automatic int list_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(4, 255);
        return $urandom_range(4, 12);
    endfunction

    function automatic void put_random_options();
        int n;
        int keep;
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 11))
                0, 1: put_type(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
                2: put_opt(dhcpr_pkg::OPT_SERVER, 4);
                3: put_opt(dhcpr_pkg::OPT_SUBNET, 4);
                4: put_opt(dhcpr_pkg::OPT_LEASE, 4);
                5: put_opt(dhcpr_pkg::OPT_ROUTER, list_len());
                6: put_opt(dhcpr_pkg::OPT_DNS, list_len());
                7: put_byte(dhcpr_pkg::OPT_PAD);
                8: put_opt(8'($urandom_range(1, 254)), $urandom_range(0, 8));
                9: put_opt(any_known_code(), $urandom_range(0, 9));
                default: put_type(8'($urandom_range(1, 255)));
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
                put_byte(dhcpr_pkg::OPT_END);
                put_bytes($urandom_range(0, 4));
            end
            7: ;
            default: begin
                if (pkt.size() > dhcpr_pkg::HDR_LEN + 1) begin
                    keep = $urandom_range(dhcpr_pkg::HDR_LEN + 1, pkt.size() - 1);
                    while (pkt.size() > keep)
                        void'(pkt.pop_back());
                end
            end
        endcase
    endfunction

    function automatic void put_options(input plan_t plan);
        case (plan)
            OPTS_FULL_SET: begin
                put_type(8'($urandom_range(1, 255)));
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_opt(dhcpr_pkg::OPT_SUBNET, 4);
                put_opt(dhcpr_pkg::OPT_ROUTER, 4);
                put_opt(dhcpr_pkg::OPT_DNS, 4);
                put_opt(dhcpr_pkg::OPT_LEASE, 4);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_TYPE_ZERO: begin
                put_type(8'd0);
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_CUT_AT_LENGTH: begin
                put_type(8'd5);
                put_byte(dhcpr_pkg::OPT_ROUTER);
            end
            OPTS_CUT_IN_DATA: begin
                put_type(8'd2);
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_byte(dhcpr_pkg::OPT_DNS);
                put_byte(8'd8);
                put_bytes(5);
            end
            OPTS_ODD_LENGTHS: begin
                put_opt(dhcpr_pkg::OPT_MSG_TYPE, 2);
                put_opt(dhcpr_pkg::OPT_SERVER, 3);
                put_opt(dhcpr_pkg::OPT_SUBNET, 5);
                put_opt(dhcpr_pkg::OPT_LEASE, 0);
                put_opt(dhcpr_pkg::OPT_ROUTER, 3);
                put_opt(dhcpr_pkg::OPT_DNS, 2);
                put_opt(8'd200, 6);
                put_type(8'd1);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_PAD_END_TAIL: begin
                put_byte(dhcpr_pkg::OPT_PAD);
                put_byte(dhcpr_pkg::OPT_PAD);
                put_type(8'd3);
                put_byte(dhcpr_pkg::OPT_PAD);
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_byte(dhcpr_pkg::OPT_END);
                put_type(8'd7);
                put_bytes(3);
            end
            OPTS_REPEATS: begin
                put_type(8'd1);
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_type(8'd5);
                put_opt(dhcpr_pkg::OPT_SERVER, 4);
                put_opt(dhcpr_pkg::OPT_ROUTER, 4);
                put_opt(dhcpr_pkg::OPT_ROUTER, 8);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_LONG_LISTS: begin
                put_type(8'd2);
                put_opt(dhcpr_pkg::OPT_ROUTER, 255);
                put_opt(dhcpr_pkg::OPT_DNS, 12);
                put_opt(8'd77, 255);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_END_IS_LAST: begin
                put_type(8'd6);
                put_opt(dhcpr_pkg::OPT_SUBNET, 4);
                put_byte(dhcpr_pkg::OPT_END);
            end
            OPTS_EMPTY_OPTION: begin
                put_type(8'd4);
                put_opt(8'd12, 0);
                put_opt(dhcpr_pkg::OPT_SERVER, 0);
                put_opt(dhcpr_pkg::OPT_DNS, 0);
            end
            OPTS_RANDOM: put_random_options();
            default: ;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(200, 600);
            else
                burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_reply(input logic typed, input dhcpr_pkg::result_t reply);
        sheet_replies.push_back('{typed, reply});
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
        replies_sent++;
    endtask

    initial begin
        packet_row_t        row;
        dhcpr_pkg::result_t reply;
        int                 random_replies;
        int                 kind;
        for (int i = 0; i < 8; i++)
            by_status[i] = 0;
        parser_clear();
        random_replies = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < $size(sheet); r++) begin
            row = sheet[r];
            put_header(row.head_len, row.fill, row.bad_at);
            put_options(row.plan);
            reply = '0;
            reply.status = row.want_status;
            reply.transaction_id = row.want_xid;
            reply.your_address = row.want_yiaddr;
            send_reply(row.typed, reply);
        end

        while (bytes_sent < ITEM_GOAL || random_replies < RANDOM_REPLIES_MIN) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                put_header($urandom_range(1, dhcpr_pkg::HDR_LEN - 1), FILL_RANDOM, 0);
            end else begin
                put_header(dhcpr_pkg::HDR_LEN, FILL_RANDOM,
                           (kind == 2) ?
                           $urandom_range(dhcpr_pkg::COOKIE_AT, dhcpr_pkg::HDR_LEN - 1) : 0);
                put_options(OPTS_RANDOM);
            end
            send_reply(1'b0, '0);
            random_replies++;
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (replies_due.size() != 0) begin
            faults += replies_due.size();
            $display("%0d expected result words never arrived", replies_due.size());
        end

        $display("Sent %0d replies in %0d bytes and checked %0d result words.", replies_sent,
                 bytes_sent, words_checked);
        $display("Statuses: ok %0d, short %0d, bad cookie %0d, truncated %0d, no type %0d.",
                 by_status[dhcpr_pkg::ST_OK], by_status[dhcpr_pkg::ST_SHORT],
                 by_status[dhcpr_pkg::ST_BAD_COOKIE], by_status[dhcpr_pkg::ST_TRUNCATED],
                 by_status[dhcpr_pkg::ST_NO_TYPE]);
        if (faults == 0) begin
            $display("tb_dhcp_reply_option_parser_top passed");
        end else begin
            $display("%0d mismatches in total", faults);
            $display("tb_dhcp_reply_option_parser_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/dhcpr_pkg.sv
design/dhcpr_parser.sv
design/dhcpr_out_reg.sv
design/dhcp_reply_option_parser_top.sv
tb/sv/tb_dhcp_reply_option_parser_top.sv
